[hw/rtl/lrs_pkg.sv]
// Package: types, codes and sizes shared by the listen/repeat sequencer files.
`default_nettype none
package lrs_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int FUNC_W      = 3;
    localparam int CMD_W       = 3;
    localparam int PHASE_W     = 3;
    localparam int SEC_W       = 16;
    localparam int STRIKE_W    = 8;
    localparam int IND_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [STRIKE_W-1:0] STRIKE_MAX = '1;
    localparam logic [STRIKE_W-1:0] FAIL_LIMIT = STRIKE_W'(3);
    localparam logic [TIMER_WIDTH-1:0] BOOP_SECONDS = TIMER_WIDTH'(1);

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_SPEAK = 3'd2,
        PH_BOOP  = 3'd3,
        PH_REC   = 3'd4,
        PH_STOP  = 3'd5
    } t_phase;

    typedef enum logic [FUNC_W-1:0] {
        EV_TICK    = 3'd0,
        EV_STOP    = 3'd1,
        EV_RESTART = 3'd2,
        EV_DONE    = 3'd3,
        EV_RESULT  = 3'd4,
        EV_RESET   = 3'd5
    } t_event;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE    = 3'd0,
        CMD_SPEAK   = 3'd1,
        CMD_BOOP    = 3'd2,
        CMD_REC     = 3'd3,
        CMD_STRIKES = 3'd4,
        CMD_FAIL    = 3'd5
    } t_cmd;

    typedef enum logic [IND_W-1:0] {
        IND_BLACK  = 2'd0,
        IND_GREEN  = 2'd1,
        IND_YELLOW = 2'd2
    } t_indicator;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOOP_ENABLED      = 2'd0,
        REG_WAIT_SECONDS      = 2'd1,
        REG_SPEAK_SECONDS     = 2'd2,
        REG_RECOGNIZE_SECONDS = 2'd3
    } t_cfg_reg;

endpackage
`default_nettype wire

[hw/rtl/lrs_in_if.sv]
// Interface: event channel into the sequencer (valid/ready plus event fields).
`default_nettype none
interface lrs_in_if
    import lrs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic              result_pass;

    modport source (output valid, output func, output result_pass, input ready);
    modport sink   (input valid, input func, input result_pass, output ready);
endinterface
`default_nettype wire

[hw/rtl/lrs_out_if.sv]
// Interface: result channel out of the sequencer (valid/ready plus result fields).
`default_nettype none
interface lrs_out_if
    import lrs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [PHASE_W-1:0]  phase;
    logic [SEC_W-1:0]    seconds_left;
    logic [STRIKE_W-1:0] strike_count;
    logic [IND_W-1:0]    indicator;
    logic                last;

    modport source (output valid, output command, output phase, output seconds_left,
                    output strike_count, output indicator, output last, input ready);
    modport sink   (input valid, input command, input phase, input seconds_left,
                    input strike_count, input indicator, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/listen_repeat_sequencer_core.sv]
// Top level: listen/repeat phrase loop sequencer with seconds timer and strike counter.
//
// One event is taken per transfer on i_in and the phase, timer and strike state are
// updated in that same cycle; the results land in one output register. Most events
// make one result item. A failed recognition that brings the strike count to exactly
// three makes two: a strikes item (last = 0) then a fail item (last = 1), which the
// output register replays from a one-bit pending flag. Throughput is one event per
// cycle while each event makes a single result and the sink keeps o_out.ready high;
// an event with two results holds the input while its fail item is still owed.
// The first result of an input transfer appears in the cycle after the transfer.
// A timer expiry on a tick is acted on within that tick. Configuration registers
// are written through i_cfg_we / i_cfg_idx / i_cfg_data and must only change while
// no transfer is in flight.
`default_nettype none
module listen_repeat_sequencer_core
    import lrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lrs_in_if.sink                     i_in,
    lrs_out_if.source                  o_out
);

    // configuration
    logic             r_loop_enabled;
    logic [SEC_W-1:0] r_wait_seconds;
    logic [SEC_W-1:0] r_speak_seconds;
    logic [SEC_W-1:0] r_rec_seconds;

    // sequencer state
    t_phase                 r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_timer, n_timer;
    logic                   r_running, n_running;
    logic [STRIKE_W-1:0]    r_strike, n_strike;

    // result register
    logic                r_out_valid;
    logic                r_pend;       // fail item still owed after current item
    t_cmd                r_cmd;
    t_phase              r_out_phase;
    logic [SEC_W-1:0]    r_out_sec;
    logic [STRIKE_W-1:0] r_out_strike;
    t_indicator          r_out_ind;
    logic                r_out_last;

    t_cmd       n_cmd;
    logic       n_fail;
    t_indicator n_ind;
    logic       in_xfer;
    logic       out_xfer;
    logic       expire;
    t_event     ev;

    assign ev       = t_event'(i_in.func);
    assign i_in.ready = !r_out_valid || (o_out.ready && !r_pend);
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = r_out_valid && o_out.ready;
    // running timer expires on a tick at count 0 or 1
    assign expire   = r_running && (r_timer <= TIMER_WIDTH'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_enabled  <= 1'b0;
            r_wait_seconds  <= '0;
            r_speak_seconds <= '0;
            r_rec_seconds   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_LOOP_ENABLED:      r_loop_enabled  <= i_cfg_data[0];
                REG_WAIT_SECONDS:      r_wait_seconds  <= i_cfg_data;
                REG_SPEAK_SECONDS:     r_speak_seconds <= i_cfg_data;
                REG_RECOGNIZE_SECONDS: r_rec_seconds   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state: phase, timer and strikes
    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_running = r_running;
        n_strike  = r_strike;
        case (ev)
            EV_TICK: begin
                if (expire) begin
                    case (r_phase)
                        PH_WAIT: begin
                            n_phase   = PH_SPEAK;
                            n_timer   = TIMER_WIDTH'(r_speak_seconds);
                            n_running = 1'b1;
                        end
                        PH_SPEAK, PH_BOOP, PH_REC: begin
                            n_phase   = PH_WAIT;
                            n_timer   = TIMER_WIDTH'(r_wait_seconds);
                            n_running = 1'b1;
                        end
                        default: begin
                            n_timer   = '0;
                            n_running = 1'b0;
                        end
                    endcase
                end else if (r_running) begin
                    n_timer = r_timer - TIMER_WIDTH'(1);
                end
            end
            EV_STOP: begin
                if (r_phase != PH_IDLE) begin
                    n_phase   = PH_STOP;
                    n_strike  = '0;
                    n_timer   = '0;
                    n_running = 1'b0;
                end
            end
            EV_RESTART: begin
                if ((r_phase == PH_IDLE && r_loop_enabled) || r_phase == PH_STOP) begin
                    n_phase   = PH_WAIT;
                    n_timer   = TIMER_WIDTH'(r_wait_seconds);
                    n_running = 1'b1;
                end
            end
            EV_DONE: begin
                if (r_phase == PH_SPEAK) begin
                    n_phase   = PH_BOOP;
                    n_timer   = BOOP_SECONDS;
                    n_running = 1'b1;
                end else if (r_phase == PH_BOOP) begin
                    n_phase   = PH_REC;
                    n_timer   = TIMER_WIDTH'(r_rec_seconds);
                    n_running = 1'b1;
                end
            end
            EV_RESULT: begin
                if (r_phase == PH_REC) begin
                    n_phase   = PH_WAIT;
                    n_timer   = TIMER_WIDTH'(r_wait_seconds);
                    n_running = 1'b1;
                    if (i_in.result_pass) begin
                        n_strike = '0;
                    end else if (r_strike != STRIKE_MAX) begin
                        n_strike = r_strike + STRIKE_W'(1);
                    end
                end
            end
            EV_RESET: begin
                if (r_phase == PH_STOP) begin
                    n_phase = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    // outputs: command code, second fail item, indicator
    always_comb begin
        n_cmd  = CMD_NONE;
        n_fail = 1'b0;
        case (ev)
            EV_TICK: begin
                if (expire && r_phase == PH_WAIT) begin
                    n_cmd = CMD_SPEAK;
                end
            end
            EV_DONE: begin
                if (r_phase == PH_SPEAK) begin
                    n_cmd = CMD_BOOP;
                end else if (r_phase == PH_BOOP) begin
                    n_cmd = CMD_REC;
                end
            end
            EV_RESULT: begin
                if (r_phase == PH_REC) begin
                    n_cmd  = CMD_STRIKES;
                    n_fail = !i_in.result_pass && (n_strike == FAIL_LIMIT);
                end
            end
            default: ;
        endcase
        if (n_phase == PH_IDLE || n_phase == PH_STOP) begin
            n_ind = IND_BLACK;
        end else if (n_strike != '0) begin
            n_ind = IND_YELLOW;
        end else begin
            n_ind = IND_GREEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_timer   <= '0;
            r_running <= 1'b0;
            r_strike  <= '0;
        end else if (in_xfer) begin
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_running <= n_running;
            r_strike  <= n_strike;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
            r_pend      <= n_fail;
        end else if (out_xfer) begin
            r_out_valid <= r_pend;
            r_pend      <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd        <= n_cmd;
            r_out_phase  <= n_phase;
            r_out_sec    <= SEC_W'(n_timer);
            r_out_strike <= n_strike;
            r_out_ind    <= n_ind;
            r_out_last   <= !n_fail;
        end else if (out_xfer && r_pend) begin
            r_cmd      <= CMD_FAIL;
            r_out_last <= 1'b1;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.command      = r_cmd;
    assign o_out.phase        = r_out_phase;
    assign o_out.seconds_left = r_out_sec;
    assign o_out.strike_count = r_out_strike;
    assign o_out.indicator    = r_out_ind;
    assign o_out.last         = r_out_last;

`ifndef SYNTHESIS
    a_pend_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_out_valid && !r_out_last && r_cmd == CMD_STRIKES)
        else $error("pending fail item without a strikes item in the output register");

    a_pend_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !i_in.ready)
        else $error("input taken while a fail item is still owed");

    a_fail_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_cmd == CMD_FAIL) |-> (r_out_strike == FAIL_LIMIT && r_out_last))
        else $error("fail item with strike count other than the limit");

    a_timer_idle_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_STOP) |-> !r_running)
        else $error("timer running in idle or stop phase");
`endif

endmodule
`default_nettype wire
